// File: src/okid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okid_pkg
// Shared types, constants and tables for the OKI ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package okid_pkg;

  localparam int IDX_W    = 6;
  localparam int PRED_W   = 11;
  localparam int STEP_W   = 11;
  localparam int PCM_W    = 16;
  localparam int CODE_W   = 4;
  localparam int BYTE_W   = 8;

  localparam logic [IDX_W-1:0]         STEP_MAX = 6'd48;
  localparam logic signed [PRED_W-1:0] PRED_MAX = 11'sd1023;
  localparam logic signed [PRED_W-1:0] PRED_MIN = -11'sd1024;

  // nibble queue between front and back
  localparam int NQ_DEPTH = 4;
  localparam int NQ_AW    = 2;
  localparam int NQ_CW    = 3;

  // result queue at the output
  localparam int RQ_DEPTH = 2;
  localparam int RQ_CW    = 2;

  // one decode request
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              clip;   // clear index and predictor first
    logic              last;   // high nibble of its byte
  } nib_t;

  // result queue status towards the top level
  typedef struct packed {
    logic [RQ_CW-1:0] count;
    logic             room;
  } rq_stat_t;

  function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    unique case (idx)
      6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
      6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
      6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
      6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
      6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
      6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
      6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
      6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
      6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
      6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
      6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
      6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
      6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
      6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
      6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
      6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
      default: s = 11'd1552;  // top entry, and anything past it
    endcase
    return s;
  endfunction

  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] a;
    unique case (mag)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: src/okid_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okid_front
// Takes code bytes and splits each into two decode requests, low nibble first.
// ----------------------------------------------------------------------------
module okid_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [7:0]                 code_byte,
  input  wire logic                       clip_start,
  output logic                            nq_push,
  output okid_pkg::nib_t                  nq_data,
  input  wire logic                       nq_full
);
  import okid_pkg::*;

  logic [BYTE_W-1:0] byte_data;
  logic              clip;
  logic              byte_valid;
  logic              half;     // 1: high nibble is next
  logic              take;

  always_comb begin
    nq_push = byte_valid && !nq_full;
    full    = byte_valid && !(nq_push && half);
    take    = push && !full;
    if (half) begin
      nq_data = '{code: byte_data[7:4], clip: 1'b0, last: 1'b1};
    end else begin
      nq_data = '{code: byte_data[3:0], clip: clip, last: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      half       <= 1'b0;
    end else if (take) begin
      byte_valid <= 1'b1;
      half       <= 1'b0;
    end else if (nq_push) begin
      if (half) begin
        byte_valid <= 1'b0;
        half       <= 1'b0;
      end else begin
        half <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_data <= code_byte;
      clip      <= clip_start;
    end
  end

endmodule
`default_nettype wire

// File: src/okid_nq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okid_nq
// Short request queue between the front and the decode back end.
// ----------------------------------------------------------------------------
module okid_nq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire okid_pkg::nib_t wdata,
  output logic                full,
  input  wire logic           pop,
  output okid_pkg::nib_t      rdata,
  output logic                empty
);
  import okid_pkg::*;

  nib_t             slot [NQ_DEPTH];
  logic [NQ_AW-1:0] wr_ptr;
  logic [NQ_AW-1:0] rd_ptr;
  logic [NQ_CW-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full    = (count == NQ_CW'(NQ_DEPTH));
    empty   = (count == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    rdata   = slot[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= wdata;
  end

endmodule
`default_nettype wire

// File: src/okid_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// okid_back
// Decodes one nibble a cycle, while the result queue has room, against the step
// index and predictor, and holds finished samples in a two-entry result queue.
// ----------------------------------------------------------------------------
module okid_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire okid_pkg::nib_t      nq_data,
  input  wire logic                nq_empty,
  output logic                     nq_pop,
  output logic signed [15:0]       pcm_sample,
  output logic                     pair_last,
  output logic                     empty,
  input  wire logic                pop,
  output okid_pkg::rq_stat_t       stat
);
  import okid_pkg::*;

  logic [IDX_W-1:0]         step_index;
  logic signed [PRED_W-1:0] predictor;

  logic [IDX_W-1:0]         idx_base;
  logic [IDX_W-1:0]         idx_sel;
  logic signed [PRED_W-1:0] pred_base;
  logic [STEP_W-1:0]        step;
  logic [3:0]               factor;
  logic [14:0]              prod;
  logic [11:0]              mag;
  logic signed [12:0]       sum;
  logic signed [PRED_W-1:0] predictor_next;
  logic signed [4:0]        adj;
  logic signed [6:0]        idx_sum;
  logic [IDX_W-1:0]         step_index_next;

  logic signed [PCM_W-1:0]  res_pcm  [RQ_DEPTH];
  logic                     res_last [RQ_DEPTH];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [RQ_CW-1:0]         count;
  logic                     do_pop;
  logic                     room;

  // result queue control
  always_comb begin
    empty      = (count == '0);
    do_pop     = pop && !empty;
    room       = (count != RQ_CW'(RQ_DEPTH)) || do_pop;
    nq_pop     = !nq_empty && room;
    pcm_sample = res_pcm[rd_ptr];
    pair_last  = res_last[rd_ptr];
    stat       = '{count: count, room: room};
  end

  // nibble decode
  always_comb begin
    idx_base  = nq_data.clip ? '0 : step_index;
    pred_base = nq_data.clip ? '0 : predictor;
    idx_sel   = (idx_base > STEP_MAX) ? STEP_MAX : idx_base;
    step      = step_lookup(idx_sel);
    factor    = {nq_data.code[2:0], 1'b1};
    prod      = 15'(factor) * 15'(step);
    mag       = prod[14:3];
    if (nq_data.code[3]) begin
      sum = 13'(pred_base) - $signed({1'b0, mag});
    end else begin
      sum = 13'(pred_base) + $signed({1'b0, mag});
    end
    if (sum > 13'(PRED_MAX)) begin
      predictor_next = PRED_MAX;
    end else if (sum < 13'(PRED_MIN)) begin
      predictor_next = PRED_MIN;
    end else begin
      predictor_next = sum[PRED_W-1:0];
    end

    adj     = index_adjust(nq_data.code[2:0]);
    idx_sum = $signed({1'b0, idx_sel}) + {{2{adj[4]}}, adj};
    if (idx_sum < 7'sd0) begin
      step_index_next = '0;
    end else if (idx_sum > $signed({1'b0, STEP_MAX})) begin
      step_index_next = STEP_MAX;
    end else begin
      step_index_next = idx_sum[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
      predictor  <= '0;
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      count      <= '0;
    end else begin
      if (nq_pop) begin
        step_index <= step_index_next;
        predictor  <= predictor_next;
        wr_ptr     <= ~wr_ptr;
      end
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (nq_pop && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !nq_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (nq_pop) begin
      res_pcm[wr_ptr]  <= {predictor_next, 5'b0};
      res_last[wr_ptr] <= nq_data.last;
    end
  end

endmodule
`default_nettype wire

// File: src/oki_adpcm_nibble_decoder.sv
`default_nettype none
// Order: a byte's low-nibble sample is shown before its high-nibble sample;
//   each passes the front byte register, nibble queue and result queue.
// Rate: the back end decodes one nibble per cycle, while the result queue has
//   room, through the shared step/predictor update.
// Reset (rst, synchronous): step index and predictor cleared, all queues
//   emptied; full is low and empty high in the cycle after reset.
// ----------------------------------------------------------------------------
// oki_adpcm_nibble_decoder
// 4-bit OKI ADPCM decoder: bytes in, two 16-bit samples out per byte.
// ----------------------------------------------------------------------------
module oki_adpcm_nibble_decoder (
  input  wire logic               clk,
  input  wire logic               rst,
  // request side: one code byte per request
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         code_byte,
  input  wire logic               clip_start,
  // result side: one sample per pop, two per code byte
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      pcm_sample,
  output logic                    pair_last
);
  import okid_pkg::*;

  // front -> nibble queue
  nib_t     fq_data;
  logic     fq_push;
  logic     fq_full;
  // nibble queue -> back
  nib_t     bq_data;
  logic     bq_pop;
  logic     bq_empty;
  rq_stat_t rq_stat;

  // Front end: holds one byte and hands its nibbles on, low first. The
  // clip flag rides only on the low nibble, so the state clear happens
  // exactly once, before the first code of the byte.
  okid_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .code_byte  (code_byte),
    .clip_start (clip_start),
    .nq_push    (fq_push),
    .nq_data    (fq_data),
    .nq_full    (fq_full)
  );

  // Decouples the splitter from the decoder so either may stall alone.
  okid_nq u_nq (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_data),
    .full  (fq_full),
    .pop   (bq_pop),
    .rdata (bq_data),
    .empty (bq_empty)
  );

  // Back end: step lookup, small multiply, predictor and index clamps, all
  // combinational, written straight into the result queue.
  okid_back u_back (
    .clk        (clk),
    .rst        (rst),
    .nq_data    (bq_data),
    .nq_empty   (bq_empty),
    .nq_pop     (bq_pop),
    .pcm_sample (pcm_sample),
    .pair_last  (pair_last),
    .empty      (empty),
    .pop        (pop),
    .stat       (rq_stat)
  );

`ifndef NO_ASSERTIONS
  // queues come up empty after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !full && empty)
    else $error("queues not clear after reset");

  // result queue never overfills
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_stat.count <= RQ_CW'(RQ_DEPTH))
    else $error("result queue overflow");

  // samples are the predictor scaled by 32
  a_pcm_scale: assert property (@(posedge clk) disable iff (rst)
    !empty |-> pcm_sample[4:0] == 5'b0)
    else $error("sample not a multiple of 32");

  // decoder only advances when the result queue can take the sample
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    bq_pop |-> rq_stat.room)
    else $error("decode with no room for result");
`endif

endmodule
`default_nettype wire
